>>> hdl/ffha_pkg.sv
// Package of the first-fit heap allocator: command and status types, operation codes,
// result codes and default sizes. No dependencies.
package ffha_pkg;

    // Default sizes of the tables and of the address range.
    localparam int FREE_ENTRIES_DEF = 64;
    localparam int USED_ENTRIES_DEF = 64;
    localparam int ADDR_BITS_DEF    = 16;
    localparam logic [15:0] HEAP_RESET = 16'd2000;

    // Register index of heap_size on the configuration port.
    localparam logic REG_HEAP_SIZE = 1'b0;

    // Result codes.
    localparam logic [2:0] ST_ALLOC   = 3'd0;
    localparam logic [2:0] ST_NOFIT   = 3'd1;
    localparam logic [2:0] ST_FREED   = 3'd2;
    localparam logic [2:0] ST_UNKNOWN = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;
    localparam logic [2:0] ST_ZERO    = 3'd5;

    // Source of the reported block start.
    localparam logic [1:0] RS_ZERO = 2'd0;
    localparam logic [1:0] RS_REL  = 2'd1;
    localparam logic [1:0] RS_FIT  = 2'd2;

    // Datapath operations.
    localparam logic [4:0] OP_NONE       = 5'd0;
    localparam logic [4:0] OP_LOAD       = 5'd1;
    localparam logic [4:0] OP_INIT       = 5'd2;
    localparam logic [4:0] OP_TSCAN      = 5'd3;
    localparam logic [4:0] OP_FSTART     = 5'd4;
    localparam logic [4:0] OP_RSCAN      = 5'd5;
    localparam logic [4:0] OP_FSCAN      = 5'd6;
    localparam logic [4:0] OP_EVAL       = 5'd7;
    localparam logic [4:0] OP_WPREV_BOTH = 5'd8;
    localparam logic [4:0] OP_WPREV      = 5'd9;
    localparam logic [4:0] OP_WNEXT      = 5'd10;
    localparam logic [4:0] OP_DSTART     = 5'd11;
    localparam logic [4:0] OP_USTART     = 5'd12;
    localparam logic [4:0] OP_SHIFT      = 5'd13;
    localparam logic [4:0] OP_DEC        = 5'd14;
    localparam logic [4:0] OP_UEND       = 5'd15;
    localparam logic [4:0] OP_RDONE      = 5'd16;
    localparam logic [4:0] OP_FSPLIT     = 5'd17;
    localparam logic [4:0] OP_FWRITE     = 5'd18;
    localparam logic [4:0] OP_OUT        = 5'd19;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic [4:0] op;
        logic       in_ready;
        logic       set_res;
        logic [2:0] res_code;
        logic [1:0] res_sel;
        logic       set_rep;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_fire;
        logic in_zero;
        logic act_free;
        logic cfg_wr;
        logic tdone;
        logic tfound;
        logic slot_free;
        logic fhit;
        logic fend;
        logic mprev;
        logic mnext;
        logic ffull;
        logic shift_done;
        logic split;
        logic out_free;
    } t_stat;

endpackage

>>> hdl/ffha_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ffha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

>>> hdl/ffha_ctrl.sv
// Controller of the first-fit heap allocator: sequences the table scans, merges and shifts.
// Depends on ffha_pkg.
module ffha_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ffha_pkg::t_stat i_stat,
    output ffha_pkg::t_cmd  o_cmd
);

    localparam logic [4:0] S_INIT   = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_TSCAN  = 5'd2;
    localparam logic [4:0] S_RSTART = 5'd3;
    localparam logic [4:0] S_RSCAN  = 5'd4;
    localparam logic [4:0] S_EVAL   = 5'd5;
    localparam logic [4:0] S_MERGE  = 5'd6;
    localparam logic [4:0] S_DSTART = 5'd7;
    localparam logic [4:0] S_USTART = 5'd8;
    localparam logic [4:0] S_SHIFTD = 5'd9;
    localparam logic [4:0] S_SHIFTU = 5'd10;
    localparam logic [4:0] S_DEND   = 5'd11;
    localparam logic [4:0] S_UEND   = 5'd12;
    localparam logic [4:0] S_RDONE  = 5'd13;
    localparam logic [4:0] S_FSTART = 5'd14;
    localparam logic [4:0] S_FSCAN  = 5'd15;
    localparam logic [4:0] S_FTAKE  = 5'd16;
    localparam logic [4:0] S_FWRITE = 5'd17;
    localparam logic [4:0] S_DONE   = 5'd18;

    logic [4:0] r_state, n_state;
    logic       r_fitctx, n_fitctx;

    // Next state and commands.
    always_comb begin
        n_state  = r_state;
        n_fitctx = r_fitctx;
        o_cmd    = '0;
        o_cmd.op = ffha_pkg::OP_NONE;
        case (r_state)
            S_INIT: begin
                o_cmd.op = ffha_pkg::OP_INIT;
                n_state  = S_IDLE;
            end
            S_IDLE: begin
                o_cmd.op       = ffha_pkg::OP_LOAD;
                o_cmd.in_ready = 1'b1;
                if (i_stat.in_fire) begin
                    if (i_stat.in_zero) begin
                        o_cmd.set_res  = 1'b1;
                        o_cmd.res_code = ffha_pkg::ST_ZERO;
                        o_cmd.res_sel  = ffha_pkg::RS_ZERO;
                        n_state        = S_DONE;
                    end else begin
                        n_state = S_TSCAN;
                    end
                end
            end
            S_TSCAN: begin
                o_cmd.op = ffha_pkg::OP_TSCAN;
                if (i_stat.tdone) begin
                    if (i_stat.tfound) begin
                        n_state = S_RSTART;
                    end else if (i_stat.act_free) begin
                        o_cmd.set_res  = 1'b1;
                        o_cmd.res_code = ffha_pkg::ST_UNKNOWN;
                        o_cmd.res_sel  = ffha_pkg::RS_ZERO;
                        n_state        = S_DONE;
                    end else if (i_stat.slot_free) begin
                        n_state = S_FSTART;
                    end else begin
                        o_cmd.set_res  = 1'b1;
                        o_cmd.res_code = ffha_pkg::ST_FULL;
                        o_cmd.res_sel  = ffha_pkg::RS_ZERO;
                        n_state        = S_DONE;
                    end
                end
            end
            S_RSTART: begin
                o_cmd.op = ffha_pkg::OP_FSTART;
                n_state  = S_RSCAN;
            end
            S_RSCAN: begin
                o_cmd.op = ffha_pkg::OP_RSCAN;
                if (i_stat.fhit || i_stat.fend) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.op = ffha_pkg::OP_EVAL;
                n_state  = S_MERGE;
            end
            S_MERGE: begin
                if (i_stat.mprev && i_stat.mnext) begin
                    o_cmd.op = ffha_pkg::OP_WPREV_BOTH;
                    n_fitctx = 1'b0;
                    n_state  = S_DSTART;
                end else if (i_stat.mprev) begin
                    o_cmd.op = ffha_pkg::OP_WPREV;
                    n_state  = S_RDONE;
                end else if (i_stat.mnext) begin
                    o_cmd.op = ffha_pkg::OP_WNEXT;
                    n_state  = S_RDONE;
                end else if (i_stat.ffull) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = ffha_pkg::ST_FULL;
                    o_cmd.res_sel  = ffha_pkg::RS_ZERO;
                    n_state        = S_DONE;
                end else begin
                    n_state = S_USTART;
                end
            end
            S_DSTART: begin
                o_cmd.op = ffha_pkg::OP_DSTART;
                n_state  = S_SHIFTD;
            end
            S_USTART: begin
                o_cmd.op = ffha_pkg::OP_USTART;
                n_state  = S_SHIFTU;
            end
            S_SHIFTD: begin
                o_cmd.op = ffha_pkg::OP_SHIFT;
                if (i_stat.shift_done) begin
                    n_state = S_DEND;
                end
            end
            S_SHIFTU: begin
                o_cmd.op = ffha_pkg::OP_SHIFT;
                if (i_stat.shift_done) begin
                    n_state = S_UEND;
                end
            end
            S_DEND: begin
                o_cmd.op = ffha_pkg::OP_DEC;
                n_state  = r_fitctx ? S_FWRITE : S_RDONE;
            end
            S_UEND: begin
                o_cmd.op = ffha_pkg::OP_UEND;
                n_state  = S_RDONE;
            end
            S_RDONE: begin
                o_cmd.op = ffha_pkg::OP_RDONE;
                if (i_stat.act_free) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = ffha_pkg::ST_FREED;
                    o_cmd.res_sel  = ffha_pkg::RS_REL;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.set_rep = 1'b1;
                    n_state       = S_FSTART;
                end
            end
            S_FSTART: begin
                o_cmd.op = ffha_pkg::OP_FSTART;
                n_state  = S_FSCAN;
            end
            S_FSCAN: begin
                o_cmd.op = ffha_pkg::OP_FSCAN;
                if (i_stat.fhit) begin
                    n_state = S_FTAKE;
                end else if (i_stat.fend) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = ffha_pkg::ST_NOFIT;
                    o_cmd.res_sel  = ffha_pkg::RS_ZERO;
                    n_state        = S_DONE;
                end
            end
            S_FTAKE: begin
                if (i_stat.split) begin
                    o_cmd.op = ffha_pkg::OP_FSPLIT;
                    n_state  = S_FWRITE;
                end else begin
                    n_fitctx = 1'b1;
                    n_state  = S_DSTART;
                end
            end
            S_FWRITE: begin
                o_cmd.op       = ffha_pkg::OP_FWRITE;
                o_cmd.set_res  = 1'b1;
                o_cmd.res_code = ffha_pkg::ST_ALLOC;
                o_cmd.res_sel  = ffha_pkg::RS_FIT;
                n_state        = S_DONE;
            end
            S_DONE: begin
                o_cmd.op = ffha_pkg::OP_OUT;
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
        // A heap_size write rebuilds the free table.
        if (i_stat.cfg_wr) begin
            n_state = S_INIT;
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_fitctx <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fitctx <= n_fitctx;
        end
    end

endmodule

>>> hdl/ffha_dp.sv
// Datapath of the first-fit heap allocator: free and tag tables, scan counters, merge
// arithmetic, configuration register and result register. Depends on ffha_pkg and ffha_ram.
module ffha_dp #(
    parameter int FREE_ENTRIES = ffha_pkg::FREE_ENTRIES_DEF,
    parameter int USED_ENTRIES = ffha_pkg::USED_ENTRIES_DEF,
    parameter int ADDR_BITS    = ffha_pkg::ADDR_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ffha_pkg::t_cmd  i_cmd,
    output ffha_pkg::t_stat o_stat,
    input  logic            i_in_valid,
    input  logic            i_action,
    input  logic [15:0]     i_tag,
    input  logic [15:0]     i_request_size,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [2:0]      o_status,
    output logic [15:0]     o_block_start,
    output logic            o_replaced,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata
);

    localparam int AW  = ADDR_BITS;
    localparam int FIW = $clog2(FREE_ENTRIES);
    localparam int FCW = FIW + 1;
    localparam int UIW = $clog2(USED_ENTRIES);
    localparam int UCW = UIW + 1;
    localparam int CW  = (AW > 16) ? AW : 16;
    localparam int FDW = 2 * AW;
    localparam int UDW = 16 + 2 * AW;
    localparam logic [FCW-1:0] FE_N = FCW'(FREE_ENTRIES);
    localparam logic [UCW-1:0] UE_N = UCW'(USED_ENTRIES);
    localparam logic [UIW-1:0] U_LAST = UIW'(USED_ENTRIES - 1);

    // Configuration and request registers.
    logic [15:0]    r_heap;
    logic           r_act;
    logic [15:0]    r_tag;
    logic [15:0]    r_size;
    logic           r_uvalid [USED_ENTRIES];

    // Tag scan.
    logic [UCW-1:0] r_uk;
    logic           r_upv;
    logic [UIW-1:0] r_upi;
    logic           r_ufound, r_uff, r_uend;
    logic [UIW-1:0] r_slot;

    // Free table scan and shift.
    logic [FCW-1:0] r_fcount, r_fk, r_fpi, r_p, r_rem;
    logic           r_fpv, r_fhit, r_fend, r_dir;
    logic [AW-1:0]  r_s, r_len, r_prev_s, r_prev_l, r_cur_s, r_cur_l;
    logic           r_mprev, r_mnext;

    // Result and output registers.
    logic [2:0]     r_res_status;
    logic [15:0]    r_res_start;
    logic           r_replaced;
    logic           r_ovalid;
    logic [2:0]     r_ostatus;
    logic [15:0]    r_ostart;
    logic           r_orep;

    // RAM ports.
    logic           f_we;
    logic [FIW-1:0] f_waddr;
    logic [FDW-1:0] f_wdata, f_rdata;
    logic           u_we;
    logic [UDW-1:0] u_wdata, u_rdata;

    logic           in_fire, cfg_wr, out_free, f_issue, u_issue;
    logic [AW-1:0]  f_rs, f_rl, u_rs, u_rl, heap_aw, size_aw;
    logic [15:0]    u_rt;
    logic [CW-1:0]  heap_cw, size_cw, cur_l_cw, f_rl_cw, rel_cw, fit_cw;
    logic [FCW-1:0] f_wa_full;

    assign in_fire  = i_in_valid && i_cmd.in_ready;
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == ffha_pkg::REG_HEAP_SIZE);
    assign out_free = !r_ovalid || i_out_ready;
    assign prdata   = (paddr[2] == ffha_pkg::REG_HEAP_SIZE) ? {16'd0, r_heap} : 32'd0;

    assign f_rs = f_rdata[FDW-1:AW];
    assign f_rl = f_rdata[AW-1:0];
    assign u_rt = u_rdata[UDW-1:2*AW];
    assign u_rs = u_rdata[2*AW-1:AW];
    assign u_rl = u_rdata[AW-1:0];

    // Values masked to the address width.
    assign heap_cw  = CW'(r_heap);
    assign heap_aw  = heap_cw[AW-1:0];
    assign size_cw  = CW'(r_size);
    assign size_aw  = size_cw[AW-1:0];
    assign cur_l_cw = CW'(r_cur_l);
    assign f_rl_cw  = CW'(f_rl);
    assign rel_cw   = CW'(r_s);
    assign fit_cw   = CW'(r_cur_s);

    // Read issue conditions for the scans and the shifter.
    assign u_issue = (i_cmd.op == ffha_pkg::OP_TSCAN) && (r_uk < UE_N) && !r_ufound && !r_uend;
    always_comb begin
        f_issue = 1'b0;
        case (i_cmd.op)
            ffha_pkg::OP_RSCAN, ffha_pkg::OP_FSCAN:
                f_issue = (r_fk < r_fcount) && !r_fhit && !r_fend;
            ffha_pkg::OP_SHIFT:
                f_issue = (r_rem != '0);
            default:
                f_issue = 1'b0;
        endcase
    end

    // Free table write port.
    always_comb begin
        f_we      = 1'b0;
        f_wa_full = r_p;
        f_wdata   = {r_s, r_len};
        case (i_cmd.op)
            ffha_pkg::OP_INIT: begin
                f_we      = 1'b1;
                f_wa_full = '0;
                f_wdata   = {{AW{1'b0}}, heap_aw};
            end
            ffha_pkg::OP_WPREV_BOTH: begin
                f_we      = 1'b1;
                f_wa_full = r_p - 1'b1;
                f_wdata   = {r_prev_s, r_prev_l + r_len + r_cur_l};
            end
            ffha_pkg::OP_WPREV: begin
                f_we      = 1'b1;
                f_wa_full = r_p - 1'b1;
                f_wdata   = {r_prev_s, r_prev_l + r_len};
            end
            ffha_pkg::OP_WNEXT: begin
                f_we    = 1'b1;
                f_wdata = {r_s, r_cur_l + r_len};
            end
            ffha_pkg::OP_SHIFT: begin
                f_we      = r_fpv;
                f_wa_full = r_dir ? (r_fpi + 1'b1) : (r_fpi - 1'b1);
                f_wdata   = f_rdata;
            end
            ffha_pkg::OP_UEND: begin
                f_we = 1'b1;
            end
            ffha_pkg::OP_FSPLIT: begin
                f_we    = 1'b1;
                f_wdata = {r_cur_s + size_aw, r_cur_l - size_aw};
            end
            default: begin
                f_we = 1'b0;
            end
        endcase
        f_waddr = f_wa_full[FIW-1:0];
    end

    // Tag table write port: only the allocation writes it.
    assign u_we    = (i_cmd.op == ffha_pkg::OP_FWRITE);
    assign u_wdata = {r_tag, r_cur_s, size_aw};

    ffha_ram #(
        .WIDTH (FDW),
        .DEPTH (FREE_ENTRIES)
    ) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (f_wdata),
        .i_raddr (r_fk[FIW-1:0]),
        .o_rdata (f_rdata)
    );

    ffha_ram #(
        .WIDTH (UDW),
        .DEPTH (USED_ENTRIES)
    ) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (u_we),
        .i_waddr (r_slot),
        .i_wdata (u_wdata),
        .i_raddr (r_uk[UIW-1:0]),
        .o_rdata (u_rdata)
    );

    // Control registers: heap size, counts, valid bits and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap   <= ffha_pkg::HEAP_RESET;
            r_fcount <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < USED_ENTRIES; i++) begin
                r_uvalid[i] <= 1'b0;
            end
        end else begin
            if (cfg_wr) begin
                r_heap <= pwdata[15:0];
                for (int i = 0; i < USED_ENTRIES; i++) begin
                    r_uvalid[i] <= 1'b0;
                end
            end
            case (i_cmd.op)
                ffha_pkg::OP_INIT:   r_fcount <= FCW'(r_heap != 16'd0);
                ffha_pkg::OP_DEC:    r_fcount <= r_fcount - 1'b1;
                ffha_pkg::OP_UEND:   r_fcount <= r_fcount + 1'b1;
                ffha_pkg::OP_RDONE:  r_uvalid[r_slot] <= 1'b0;
                ffha_pkg::OP_FWRITE: r_uvalid[r_slot] <= 1'b1;
                default: begin
                end
            endcase
            if ((i_cmd.op == ffha_pkg::OP_OUT) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Request latch and tag table scan.
    always_ff @(posedge i_clk) begin
        r_upv <= u_issue;
        r_upi <= r_uk[UIW-1:0];
        if (in_fire) begin
            r_act    <= i_action;
            r_tag    <= i_tag;
            r_size   <= i_request_size;
            r_uk     <= '0;
            r_ufound <= 1'b0;
            r_uff    <= 1'b0;
            r_uend   <= 1'b0;
        end else if (i_cmd.op == ffha_pkg::OP_TSCAN) begin
            if (u_issue) begin
                r_uk <= r_uk + 1'b1;
            end
            if (r_upv && !r_ufound) begin
                if (r_uvalid[r_upi] && (u_rt == r_tag)) begin
                    r_ufound <= 1'b1;
                    r_slot   <= r_upi;
                    r_s      <= u_rs;
                    r_len    <= u_rl;
                end else if (!r_uvalid[r_upi] && !r_uff) begin
                    r_uff  <= 1'b1;
                    r_slot <= r_upi;
                end
                if (r_upi == U_LAST) begin
                    r_uend <= 1'b1;
                end
            end
        end
    end

    // Free table scan, neighbour checks and shift counters.
    always_ff @(posedge i_clk) begin
        r_fpv <= f_issue;
        r_fpi <= r_fk;
        case (i_cmd.op)
            ffha_pkg::OP_FSTART: begin
                r_fk   <= '0;
                r_fhit <= 1'b0;
                r_fend <= (r_fcount == '0);
                r_p    <= '0;
            end
            ffha_pkg::OP_RSCAN: begin
                if (f_issue) begin
                    r_fk <= r_fk + 1'b1;
                end
                if (r_fpv && !r_fhit && !r_fend) begin
                    if (f_rs > r_s) begin
                        r_fhit  <= 1'b1;
                        r_p     <= r_fpi;
                        r_cur_s <= f_rs;
                        r_cur_l <= f_rl;
                    end else begin
                        r_prev_s <= f_rs;
                        r_prev_l <= f_rl;
                        r_p      <= r_fpi + 1'b1;
                        if (r_fpi + 1'b1 == r_fcount) begin
                            r_fend <= 1'b1;
                        end
                    end
                end
            end
            ffha_pkg::OP_FSCAN: begin
                if (f_issue) begin
                    r_fk <= r_fk + 1'b1;
                end
                if (r_fpv && !r_fhit && !r_fend) begin
                    if (f_rl_cw >= size_cw) begin
                        r_fhit  <= 1'b1;
                        r_p     <= r_fpi;
                        r_cur_s <= f_rs;
                        r_cur_l <= f_rl;
                    end else if (r_fpi + 1'b1 == r_fcount) begin
                        r_fend <= 1'b1;
                    end
                end
            end
            ffha_pkg::OP_EVAL: begin
                r_mprev <= (r_p != '0) && ((r_prev_s + r_prev_l) == r_s);
                r_mnext <= r_fhit && ((r_s + r_len) == r_cur_s);
            end
            ffha_pkg::OP_DSTART: begin
                r_dir <= 1'b0;
                r_fk  <= r_p + 1'b1;
                r_rem <= r_fcount - 1'b1 - r_p;
            end
            ffha_pkg::OP_USTART: begin
                r_dir <= 1'b1;
                r_fk  <= r_fcount - 1'b1;
                r_rem <= r_fcount - r_p;
            end
            ffha_pkg::OP_SHIFT: begin
                if (f_issue) begin
                    r_fk  <= r_dir ? (r_fk - 1'b1) : (r_fk + 1'b1);
                    r_rem <= r_rem - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Result register and output register.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_replaced <= 1'b0;
        end else if (i_cmd.set_rep) begin
            r_replaced <= 1'b1;
        end
        if (i_cmd.set_res) begin
            r_res_status <= i_cmd.res_code;
            case (i_cmd.res_sel)
                ffha_pkg::RS_REL: r_res_start <= rel_cw[15:0];
                ffha_pkg::RS_FIT: r_res_start <= fit_cw[15:0];
                default:          r_res_start <= 16'd0;
            endcase
        end
        if ((i_cmd.op == ffha_pkg::OP_OUT) && out_free) begin
            r_ostatus <= r_res_status;
            r_ostart  <= r_res_start;
            r_orep    <= r_replaced;
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_status      = r_ostatus;
    assign o_block_start = r_ostart;
    assign o_replaced    = r_orep;

    // Status to the controller.
    always_comb begin
        o_stat            = '0;
        o_stat.in_fire    = in_fire;
        o_stat.in_zero    = !i_action && (i_request_size == 16'd0);
        o_stat.act_free   = r_act;
        o_stat.cfg_wr     = cfg_wr;
        o_stat.tdone      = r_ufound || r_uend;
        o_stat.tfound     = r_ufound;
        o_stat.slot_free  = r_uff;
        o_stat.fhit       = r_fhit;
        o_stat.fend       = r_fend;
        o_stat.mprev      = r_mprev;
        o_stat.mnext      = r_mnext;
        o_stat.ffull      = (r_fcount >= FE_N);
        o_stat.shift_done = (r_rem == '0) && !r_fpv;
        o_stat.split      = (cur_l_cw > size_cw);
        o_stat.out_free   = out_free;
    end

endmodule

>>> hdl/first_fit_heap_allocator_unit.sv
// First-fit heap allocator: top level joining the controller and the datapath.
// Depends on ffha_pkg, ffha_ctrl, ffha_dp and ffha_ram.
// A zero-size allocate goes straight to its result; other requests take a tag table pass,
// one or two free table passes and up to two entry shifts.
// One request is in work at a time; the next is taken once the result sits in the output register.
// Reset and each heap_size write leave one free extent (none for a size of zero) after one
// rebuild cycle; the tags are cleared.
module first_fit_heap_allocator_unit #(
    parameter int FREE_ENTRIES = ffha_pkg::FREE_ENTRIES_DEF,
    parameter int USED_ENTRIES = ffha_pkg::USED_ENTRIES_DEF,
    parameter int ADDR_BITS    = ffha_pkg::ADDR_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [15:0] i_tag,
    input  logic [15:0] i_request_size,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [15:0] o_block_start,
    output logic        o_replaced,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    ffha_pkg::t_cmd  cmd;
    ffha_pkg::t_stat stat;

    assign pready     = 1'b1;
    assign o_in_ready = cmd.in_ready;

    // Sequencer.
    ffha_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Tables and arithmetic.
    ffha_dp #(
        .FREE_ENTRIES (FREE_ENTRIES),
        .USED_ENTRIES (USED_ENTRIES),
        .ADDR_BITS    (ADDR_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_in_valid     (i_in_valid),
        .i_action       (i_action),
        .i_tag          (i_tag),
        .i_request_size (i_request_size),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_block_start  (o_block_start),
        .o_replaced     (o_replaced),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata)
    );

endmodule

>>> verif/first_fit_heap_allocator_unit_test.sv
// Self-checking testbench of the first-fit heap allocator unit: directed table, fragmentation
// sequence and random requests, checked against an in-bench allocator model or fixed table results.
// Depends on ffha_pkg and first_fit_heap_allocator_unit.
`timescale 1ns / 100ps

module first_fit_heap_allocator_unit_test;

    localparam bit ACT_ALLOC = 1'b0;
    localparam bit ACT_FREE  = 1'b1;
    localparam int NFREE = ffha_pkg::FREE_ENTRIES_DEF;
    localparam int NUSED = ffha_pkg::USED_ENTRIES_DEF;
    localparam int SETTLE_CYCLES = 250;
    localparam longint CYCLE_LIMIT = 2500000;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] start;
        logic        replaced;
    } t_alloc_result;

    typedef struct {
        bit            action;
        logic [15:0]   tag;
        logic [15:0]   size;
        bit            typed;
        t_alloc_result res;
    } t_directed_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_action;
    logic [15:0] i_tag;
    logic [15:0] i_request_size;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_status;
    logic [15:0] o_block_start;
    logic        o_replaced;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    first_fit_heap_allocator_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_action(i_action), .i_tag(i_tag), .i_request_size(i_request_size),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_status(o_status), .o_block_start(o_block_start), .o_replaced(o_replaced),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Model state of the heap: sorted free extents and the tag table.
    logic [15:0] ext_start [NFREE];
    logic [15:0] ext_len   [NFREE];
    int          ext_count;
    logic [15:0] blk_tag   [NUSED];
    logic [15:0] blk_start [NUSED];
    logic [15:0] blk_len   [NUSED];
    bit          blk_live  [NUSED];

    t_alloc_result pending_results[$];
    int  error_count;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_request;
    longint cycle_count = 0;

    // Clock, 20 ns period.
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("first_fit_heap_allocator_unit: mismatch");
            $finish;
        end
    end

    // Rebuild the heap as one extent of the given size, with no tag in use.
    function automatic void heap_rebuild(input logic [15:0] units);
        for (int i = 0; i < NUSED; i++) blk_live[i] = 1'b0;
        ext_start[0] = '0;
        ext_len[0]   = units;
        ext_count    = (units == 0) ? 0 : 1;
    endfunction

    function automatic int tag_lookup(input logic [15:0] tag);
        for (int i = 0; i < NUSED; i++)
            if (blk_live[i] && blk_tag[i] == tag) return i;
        return -1;
    endfunction

    function automatic void extent_remove(input int idx);
        for (int i = idx; i + 1 < ext_count; i++) begin
            ext_start[i] = ext_start[i + 1];
            ext_len[i]   = ext_len[i + 1];
        end
        if (ext_count > 0) ext_count--;
    endfunction

    // Return a block to the free table, merging with touching neighbours.
    function automatic bit block_return(input int u);
        logic [15:0] s;
        logic [15:0] len;
        logic [15:0] prev_end;
        logic [15:0] blk_end;
        int p;
        bit mprev;
        bit mnext;
        s = blk_start[u];
        len = blk_len[u];
        p = 0;
        while (p < ext_count && ext_start[p] <= s) p++;
        mprev = 1'b0;
        if (p > 0) begin
            prev_end = ext_start[p - 1] + ext_len[p - 1];
            mprev = (prev_end == s);
        end
        blk_end = s + len;
        mnext = (p < ext_count) && (blk_end == ext_start[p]);
        if (mprev && mnext) begin
            ext_len[p - 1] = ext_len[p - 1] + len + ext_len[p];
            extent_remove(p);
        end else if (mprev) begin
            ext_len[p - 1] = ext_len[p - 1] + len;
        end else if (mnext) begin
            ext_start[p] = s;
            ext_len[p]   = ext_len[p] + len;
        end else begin
            if (ext_count >= NFREE) return 1'b0;
            for (int i = ext_count; i > p; i--) begin
                ext_start[i] = ext_start[i - 1];
                ext_len[i]   = ext_len[i - 1];
            end
            ext_start[p] = s;
            ext_len[p]   = len;
            ext_count++;
        end
        blk_live[u] = 1'b0;
        return 1'b1;
    endfunction

    // Work out the result of one request and update the model heap.
    function automatic t_alloc_result heap_predict(input bit action, input logic [15:0] tag,
                                                   input logic [15:0] size);
        t_alloc_result r;
        int u;
        int slot;
        int i;
        r = '0;
        if (action == ACT_FREE) begin
            u = tag_lookup(tag);
            if (u < 0) begin
                r.status = ffha_pkg::ST_UNKNOWN;
            end else if (block_return(u)) begin
                r.status = ffha_pkg::ST_FREED;
                r.start  = blk_start[u];
            end else begin
                r.status = ffha_pkg::ST_FULL;
            end
        end else if (size == 0) begin
            r.status = ffha_pkg::ST_ZERO;
        end else begin
            r.status = ffha_pkg::ST_NOFIT;
            slot = tag_lookup(tag);
            if (slot >= 0) begin
                if (!block_return(slot)) begin
                    r.status = ffha_pkg::ST_FULL;
                    slot = -2;
                end else begin
                    r.replaced = 1'b1;
                end
            end else begin
                slot = -2;
                for (u = 0; u < NUSED; u++)
                    if (!blk_live[u]) begin
                        slot = u;
                        break;
                    end
                if (slot < 0) r.status = ffha_pkg::ST_FULL;
            end
            if (slot >= 0) begin
                for (i = 0; i < ext_count; i++)
                    if (ext_len[i] >= size) break;
                if (i < ext_count) begin
                    r.start = ext_start[i];
                    if (ext_len[i] > size) begin
                        ext_start[i] = ext_start[i] + size;
                        ext_len[i]   = ext_len[i] - size;
                    end else begin
                        extent_remove(i);
                    end
                    blk_live[slot]  = 1'b1;
                    blk_tag[slot]   = tag;
                    blk_start[slot] = r.start;
                    blk_len[slot]   = size;
                    r.status = ffha_pkg::ST_ALLOC;
                end
            end
        end
        return r;
    endfunction

    // Offer one request and wait for it to be taken; returns the model's result.
    task automatic send_request(input bit action, input logic [15:0] tag,
                                input logic [15:0] size, output t_alloc_result r);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     = 1'b1;
        i_action       = action;
        i_tag          = tag;
        i_request_size = size;
        do @(posedge i_clk); while (!o_in_ready);
        r = heap_predict(action, tag, size);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic issue(input bit action, input logic [15:0] tag, input logic [15:0] size);
        t_alloc_result r;
        send_request(action, tag, size, r);
        pending_results.push_back(r);
    endtask

    // Wait for all results, let the block settle, then write heap_size.
    task automatic set_heap_size(input logic [15:0] units);
        wait (pending_results.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        paddr   = 3'(4 * int'(ffha_pkg::REG_HEAP_SIZE));
        pwdata  = {16'h0, units};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        heap_rebuild(units);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        repeat (4) @(negedge i_clk);
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    always begin
        @(negedge i_clk);
        if (hold_request) begin
            i_out_ready = 1'b0;
            repeat (3000) @(negedge i_clk);
            hold_request = 1'b0;
        end
        i_out_ready = ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each taken result with the oldest expectation.
    always @(posedge i_clk) begin
        t_alloc_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result status=%0d start=%0d replaced=%0d",
                         $time, o_status, o_block_start, o_replaced);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d got %0d", $time, want.status, o_status);
                    error_count++;
                end
                if (o_block_start !== want.start) begin
                    $display("%0t: block_start expected %0d got %0d",
                             $time, want.start, o_block_start);
                    error_count++;
                end
                if (o_replaced !== want.replaced) begin
                    $display("%0t: replaced expected %0d got %0d",
                             $time, want.replaced, o_replaced);
                    error_count++;
                end
            end
        end
    end

    t_directed_row directed[] = '{
        '{ACT_ALLOC, 16'd5,    16'd0,    1'b1, '{ffha_pkg::ST_ZERO,    16'd0,   1'b0}},
        '{ACT_FREE,  16'd9,    16'd0,    1'b1, '{ffha_pkg::ST_UNKNOWN, 16'd0,   1'b0}},
        '{ACT_ALLOC, 16'd1,    16'hFFFF, 1'b1, '{ffha_pkg::ST_NOFIT,   16'd0,   1'b0}},
        '{ACT_ALLOC, 16'hFFFF, 16'd100,  1'b1, '{ffha_pkg::ST_ALLOC,   16'd0,   1'b0}},
        '{ACT_ALLOC, 16'd1,    16'd1900, 1'b1, '{ffha_pkg::ST_ALLOC,   16'd100, 1'b0}},
        '{ACT_ALLOC, 16'd2,    16'd1,    1'b1, '{ffha_pkg::ST_NOFIT,   16'd0,   1'b0}},
        '{ACT_FREE,  16'hFFFF, 16'hFFFF, 1'b1, '{ffha_pkg::ST_FREED,   16'd0,   1'b0}},
        '{ACT_ALLOC, 16'd1,    16'd50,   1'b0, '0},
        '{ACT_ALLOC, 16'd0,    16'd1,    1'b0, '0},
        '{ACT_ALLOC, 16'd3,    16'd10,   1'b0, '0},
        '{ACT_FREE,  16'd0,    16'd0,    1'b0, '0},
        '{ACT_FREE,  16'd1,    16'd7,    1'b0, '0},
        '{ACT_ALLOC, 16'd3,    16'd2000, 1'b0, '0},
        '{ACT_FREE,  16'd3,    16'd0,    1'b0, '0},
        '{ACT_ALLOC, 16'h8000, 16'h8000, 1'b0, '0},
        '{ACT_ALLOC, 16'h7FFF, 16'd2000, 1'b0, '0},
        '{ACT_ALLOC, 16'h5555, 16'd1,    1'b0, '0},
        '{ACT_FREE,  16'h7FFF, 16'd0,    1'b0, '0},
        '{ACT_ALLOC, 16'hAAAA, 16'd1999, 1'b0, '0}
    };

    logic [15:0] heap_plan [6] = '{16'd2000, 16'd1, 16'hFFFF, 16'd300, 16'd40, 16'hFFFF};

    // Main sequence.
    initial begin
        t_alloc_result r;
        logic [15:0] tag_hi;
        logic [15:0] tg;
        logic [15:0] sz;
        int size_cap;
        bit act;
        error_count    = 0;
        send_idle_pct  = 32;
        recv_idle_pct  = 77;
        hold_request   = 1'b0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_action       = 1'b0;
        i_tag          = '0;
        i_request_size = '0;
        i_out_ready    = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        heap_rebuild(ffha_pkg::HEAP_RESET);
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (4) @(negedge i_clk);

        // Directed table from reset.
        foreach (directed[k]) begin
            send_request(directed[k].action, directed[k].tag, directed[k].size, r);
            pending_results.push_back(directed[k].typed ? directed[k].res : r);
        end

        // Fill the tag table, then fragment the heap until the free table fills.
        set_heap_size(16'hFFFF);
        for (int t = 0; t < NUSED; t++) issue(ACT_ALLOC, 16'(t), 16'd1);
        issue(ACT_ALLOC, 16'hABCD, 16'd1);
        for (int k = 0; k < 6; k++)
            for (int t = 0; t < NUSED; t += (2 << k)) issue(ACT_ALLOC, 16'(t), 16'(k + 2));
        issue(ACT_ALLOC, 16'd1, 16'd9);
        for (int t = 0; t < NUSED; t++) issue(ACT_FREE, 16'(t), 16'd0);
        issue(ACT_FREE, 16'd5, 16'd0);

        // Random requests over several heap sizes and handshake paces.
        for (int seg = 0; seg < 6; seg++) begin
            set_heap_size(heap_plan[seg]);
            send_idle_pct = (seg < 2) ? 32 : (seg < 4) ? 77 : 0;
            recv_idle_pct = (seg < 2) ? 77 : (seg < 4) ? 32 : 0;
            tag_hi   = 16'($urandom);
            size_cap = (heap_plan[seg] / 6 > 1) ? heap_plan[seg] / 6 : 1;
            for (int n = 0; n < 305; n++) begin
                if (seg == 4 && n == 50) hold_request = 1'b1;
                act = ($urandom_range(99) < 40);
                tg = ($urandom_range(99) < 85) ? {tag_hi[15:4], 4'($urandom)} : 16'($urandom);
                case ($urandom_range(99)) inside
                    [0:4]:   sz = 16'd0;
                    [5:12]:  sz = 16'($urandom);
                    default: sz = 16'($urandom_range(size_cap, 1));
                endcase
                issue(act, tg, sz);
            end
        end

        wait (pending_results.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("first_fit_heap_allocator_unit: match");
        end else begin
            $display("first_fit_heap_allocator_unit: mismatch");
        end
        $finish;
    end

endmodule
